@@ rtl/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// S.BUS frame receiver package
// Shared constants, register indexes and the controller state type.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned NIB_W       = 4;
    localparam int unsigned POS_W       = 5;
    localparam int unsigned CH_IDX_W    = 4;
    localparam int unsigned CH_W        = 11;
    localparam int unsigned PAYLOAD_LEN = 22;
    localparam int unsigned PAYLOAD_AW  = $clog2(PAYLOAD_LEN);
    localparam int unsigned NUM_CH      = 16;
    localparam int unsigned FLAG_POS    = 23;
    localparam int unsigned FOOTER_POS  = 24;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned BUF_W       = CH_W - 1 + BYTE_W;
    localparam int unsigned CNT_W       = $clog2(BUF_W + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOOTER     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALT_FOOTER = 2'd2;

    localparam logic [BYTE_W-1:0] HEADER_RESET     = 8'h0F;
    localparam logic [BYTE_W-1:0] FOOTER_RESET     = 8'h00;
    localparam logic [NIB_W-1:0]  ALT_FOOTER_RESET = 4'h4;

    typedef enum logic [3:0] {
        S_RX    = 4'b0001,
        S_READ  = 4'b0010,
        S_MERGE = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

endpackage

@@ rtl/sfr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sfr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 22
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sbus_frame_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// S.BUS frame receiver
// Hunts for the header byte, stores the 22 payload bytes of a 25-byte frame,
// checks the footer and unpacks sixteen 11-bit channels or one error result.
// ----------------------------------------------------------------------------
// Received bytes are taken one per cycle while a frame is being collected,
// except that the footer byte waits for a free output register. After a good
// footer the payload RAM is read back a byte at a time through its single read
// port, and each channel is emitted as soon as eleven bits are available; no
// byte is taken during unpacking. A bad footer gives its error result directly
// from the footer transaction. The configuration port is always ready and is
// meant to be written while the block is idle.
module sbus_frame_receiver_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfr_pkg::BYTE_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [sfr_pkg::BYTE_W-1:0]     i_rx_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [sfr_pkg::CH_IDX_W-1:0]   o_channel_index,
    output logic [sfr_pkg::CH_W-1:0]       o_channel_value,
    output logic                           o_frame_bad,
    output logic                           o_last
);
    import sfr_pkg::*;

    t_state                r_state, n_state;
    logic [BYTE_W-1:0]     r_header, n_header;
    logic [BYTE_W-1:0]     r_footer, n_footer;
    logic [NIB_W-1:0]      r_alt_footer, n_alt_footer;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [PAYLOAD_AW-1:0] r_rd_idx, n_rd_idx;
    logic [BUF_W-1:0]      r_buf, n_buf;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [CH_IDX_W-1:0]   r_ch, n_ch;
    logic                  r_out_valid, n_out_valid;
    logic [CH_IDX_W-1:0]   r_out_index, n_out_index;
    logic [CH_W-1:0]       r_out_value, n_out_value;
    logic                  r_out_bad, n_out_bad;
    logic                  r_out_last, n_out_last;

    logic                  cfg_we;
    logic                  in_fire;
    logic                  out_free;
    logic                  hunting;
    logic                  at_footer;
    logic                  footer_ok;
    logic                  ram_we;
    logic [PAYLOAD_AW-1:0] ram_waddr;
    logic [BYTE_W-1:0]     ram_rdata;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    assign out_free  = !r_out_valid || i_out_ready;
    assign hunting   = (r_pos == '0) || (r_pos > POS_W'(FOOTER_POS));
    assign at_footer = (r_pos == POS_W'(FOOTER_POS));
    assign footer_ok = (i_rx_byte == r_footer) || (i_rx_byte[NIB_W-1:0] == r_alt_footer);

    assign o_in_ready = (r_state == S_RX) && (!at_footer || out_free);
    assign in_fire    = i_in_valid && o_in_ready;

    assign ram_we    = in_fire && !hunting && (r_pos < POS_W'(FLAG_POS));
    assign ram_waddr = PAYLOAD_AW'(r_pos - POS_W'(1));

    sfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAYLOAD_LEN)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_rx_byte),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_header     = r_header;
        n_footer     = r_footer;
        n_alt_footer = r_alt_footer;
        if (cfg_we) begin
            case (i_cfg_index)
                CFG_HEADER:     n_header     = i_cfg_data;
                CFG_FOOTER:     n_footer     = i_cfg_data;
                CFG_ALT_FOOTER: n_alt_footer = i_cfg_data[NIB_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_rd_idx    = r_rd_idx;
        n_buf       = r_buf;
        n_cnt       = r_cnt;
        n_ch        = r_ch;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_index = r_out_index;
        n_out_value = r_out_value;
        n_out_bad   = r_out_bad;
        n_out_last  = r_out_last;

        case (r_state)
            S_RX: begin
                if (in_fire) begin
                    if (hunting) begin
                        n_pos = (i_rx_byte == r_header) ? POS_W'(1) : '0;
                    end else if (at_footer) begin
                        n_pos = '0;
                        if (footer_ok) begin
                            n_rd_idx = '0;
                            n_buf    = '0;
                            n_cnt    = '0;
                            n_ch     = '0;
                            n_state  = S_READ;
                        end else begin
                            n_out_valid = 1'b1;
                            n_out_index = '0;
                            n_out_value = '0;
                            n_out_bad   = 1'b1;
                            n_out_last  = 1'b1;
                        end
                    end else begin
                        n_pos = r_pos + POS_W'(1);
                    end
                end
            end
            S_READ: begin
                n_state = S_MERGE;
            end
            S_MERGE: begin
                n_buf    = r_buf | (BUF_W'(ram_rdata) << r_cnt);
                n_cnt    = r_cnt + CNT_W'(BYTE_W);
                n_rd_idx = r_rd_idx + PAYLOAD_AW'(1);
                n_state  = (r_cnt + CNT_W'(BYTE_W) >= CNT_W'(CH_W)) ? S_EMIT : S_READ;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_index = r_ch;
                    n_out_value = r_buf[CH_W-1:0];
                    n_out_bad   = 1'b0;
                    n_out_last  = (r_ch == CH_IDX_W'(NUM_CH - 1));
                    n_buf       = r_buf >> CH_W;
                    n_cnt       = r_cnt - CNT_W'(CH_W);
                    n_ch        = r_ch + CH_IDX_W'(1);
                    if (r_ch == CH_IDX_W'(NUM_CH - 1)) begin
                        n_state = S_RX;
                    end else if (r_cnt >= CNT_W'(2 * CH_W)) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_RX;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_RX;
            r_header     <= HEADER_RESET;
            r_footer     <= FOOTER_RESET;
            r_alt_footer <= ALT_FOOTER_RESET;
            r_pos        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_header     <= n_header;
            r_footer     <= n_footer;
            r_alt_footer <= n_alt_footer;
            r_pos        <= n_pos;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx    <= n_rd_idx;
        r_buf       <= n_buf;
        r_cnt       <= n_cnt;
        r_ch        <= n_ch;
        r_out_index <= n_out_index;
        r_out_value <= n_out_value;
        r_out_bad   <= n_out_bad;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_channel_index = r_out_index;
    assign o_channel_value = r_out_value;
    assign o_frame_bad     = r_out_bad;
    assign o_last          = r_out_last;

endmodule
